// ----- design/light_bar_quad_validator_unit_defines.svh -----
// Assertion macros for the light bar quad validator.
`ifndef LIGHT_BAR_QUAD_VALIDATOR_UNIT_DEFINES_SVH
`define LIGHT_BAR_QUAD_VALIDATOR_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define LBQV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LBQV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/lbqv_pkg.sv -----
`timescale 1ns / 1ps

package lbqv_pkg;

    // default geometry of a corner coordinate
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;

    // register widths
    localparam int RATIO_W = 5;
    localparam int AREA_W  = 16;
    localparam int SLOPE_W = 12;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MAX_RATIO   = 2'd0;
    localparam cfg_idx_t CFG_MIN_AREA    = 2'd1;
    localparam cfg_idx_t CFG_ANGLE_SLOPE = 2'd2;

    localparam logic [RATIO_W-1:0] MAX_RATIO_RST   = 5'd10;
    localparam logic [AREA_W-1:0]  MIN_AREA_RST    = 16'd300;
    localparam logic [SLOPE_W-1:0] ANGLE_SLOPE_RST = 12'd443;

    // fraction bits of the tilt slope
    localparam int ANGLE_FRAC = 8;

    // verdict codes
    localparam int VERDICT_W = 2;
    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_OK    = 2'd0;
    localparam verdict_t VERDICT_ANGLE = 2'd1;
    localparam verdict_t VERDICT_RATIO = 2'd2;
    localparam verdict_t VERDICT_AREA  = 2'd3;

endpackage

// ----- design/light_bar_quad_validator_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one beat per cycle while in_stall is low; empty stages are filled while the output waits.
// in_stall rises only when every stage holds a beat and the output is stalled.
// Reset (rst_n low, async): all stage valids cleared, configuration registers back to defaults.
// The full area product is built from four partial products over two stages.

module light_bar_quad_validator_unit #(
    parameter int COORD_BITS = lbqv_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lbqv_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_wr_en,
    input  lbqv_pkg::cfg_idx_t                   cfg_index,
    input  logic [lbqv_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_BITS-1:0]         corner_a_x,
    input  logic signed [COORD_BITS-1:0]         corner_a_y,
    input  logic signed [COORD_BITS-1:0]         corner_b_x,
    input  logic signed [COORD_BITS-1:0]         corner_b_y,
    input  logic signed [COORD_BITS-1:0]         corner_c_x,
    input  logic signed [COORD_BITS-1:0]         corner_c_y,
    input  logic signed [COORD_BITS-1:0]         corner_d_x,
    input  logic signed [COORD_BITS-1:0]         corner_d_y,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lbqv_pkg::verdict_t                   verdict
);

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int STAGES = 8;
    localparam int C      = COORD_BITS;
    localparam int SUM_W  = C + 2;                  // twice a midpoint difference
    localparam int ADX_W  = C + 1;                  // |DX|, and DY once known positive
    localparam int DIF_W  = C + 1;                  // corner to corner delta
    localparam int SQ_W   = 2 * C;                  // square of one delta
    localparam int D2_W   = 2 * C + 1;              // squared edge length
    localparam int SP_W   = lbqv_pkg::SLOPE_W + ADX_W;
    localparam int R2_W   = 2 * lbqv_pkg::RATIO_W;
    localparam int RW_W   = R2_W + D2_W;
    localparam int LO_W   = (D2_W + 1) / 2;         // low half of the area split
    localparam int HI_W   = D2_W - LO_W;
    localparam int AP_W   = 2 * D2_W;               // full area product
    localparam int A2_W   = 2 * lbqv_pkg::AREA_W;
    localparam int THR_W  = A2_W + 4 * FRAC_BITS;
    localparam int CMP_W  = (AP_W > THR_W) ? AP_W : THR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lbqv_pkg::RATIO_W-1:0] max_ratio_reg;
    logic [lbqv_pkg::AREA_W-1:0]  min_area_reg;
    logic [lbqv_pkg::SLOPE_W-1:0] angle_slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ratio_reg   <= lbqv_pkg::MAX_RATIO_RST;
            min_area_reg    <= lbqv_pkg::MIN_AREA_RST;
            angle_slope_reg <= lbqv_pkg::ANGLE_SLOPE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lbqv_pkg::CFG_MAX_RATIO:
                    max_ratio_reg <= cfg_data[lbqv_pkg::RATIO_W-1:0];
                lbqv_pkg::CFG_MIN_AREA:
                    min_area_reg <= cfg_data[lbqv_pkg::AREA_W-1:0];
                lbqv_pkg::CFG_ANGLE_SLOPE:
                    angle_slope_reg <= cfg_data[lbqv_pkg::SLOPE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Squared ratio and area threshold, refreshed every cycle. Write only while the pipe is
    // empty (the block does not enforce this), so that a beat never sees a stale copy.
    logic [R2_W-1:0]  r2_reg;
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk)
    begin
        r2_reg  <= R2_W'(max_ratio_reg) * R2_W'(max_ratio_reg);
        thr_reg <= THR_W'(A2_W'(min_area_reg) * A2_W'(min_area_reg)) << (4 * FRAC_BITS);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when the stage
    // after it loads, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] ld;

    always_comb
    begin
        ld[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = ld[0] ? in_valid : v_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = v_reg[STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: selection pass for slot 0 (swap on strictly smaller y)
    // ------------------------------------------------------------------
    logic signed [C-1:0] s1_x_next [4];
    logic signed [C-1:0] s1_y_next [4];
    logic signed [C-1:0] s1_x_reg  [4];
    logic signed [C-1:0] s1_y_reg  [4];

    always_comb
    begin
        logic signed [C-1:0] tx;
        logic signed [C-1:0] ty;
        tx           = '0;
        ty           = '0;
        s1_x_next[0] = corner_a_x;
        s1_y_next[0] = corner_a_y;
        s1_x_next[1] = corner_b_x;
        s1_y_next[1] = corner_b_y;
        s1_x_next[2] = corner_c_x;
        s1_y_next[2] = corner_c_y;
        s1_x_next[3] = corner_d_x;
        s1_y_next[3] = corner_d_y;
        for (int j = 1; j < 4; j++)
        begin
            if (s1_y_next[j] < s1_y_next[0])
            begin
                tx           = s1_x_next[0];
                ty           = s1_y_next[0];
                s1_x_next[0] = s1_x_next[j];
                s1_y_next[0] = s1_y_next[j];
                s1_x_next[j] = tx;
                s1_y_next[j] = ty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_x_reg <= s1_x_next;
            s1_y_reg <= s1_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: selection passes for slots 1 and 2
    // ------------------------------------------------------------------
    logic signed [C-1:0] s2_x_next [4];
    logic signed [C-1:0] s2_y_next [4];
    logic signed [C-1:0] s2_x_reg  [4];
    logic signed [C-1:0] s2_y_reg  [4];

    always_comb
    begin
        logic signed [C-1:0] tx;
        logic signed [C-1:0] ty;
        tx        = '0;
        ty        = '0;
        s2_x_next = s1_x_reg;
        s2_y_next = s1_y_reg;
        for (int i = 1; i < 3; i++)
        begin
            for (int j = i + 1; j < 4; j++)
            begin
                if (s2_y_next[j] < s2_y_next[i])
                begin
                    tx           = s2_x_next[i];
                    ty           = s2_y_next[i];
                    s2_x_next[i] = s2_x_next[j];
                    s2_y_next[i] = s2_y_next[j];
                    s2_x_next[j] = tx;
                    s2_y_next[j] = ty;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s2_x_reg <= s2_x_next;
            s2_y_reg <= s2_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: midpoint differences (doubled) and edge deltas.
    // Corners 0/1 are the top edge, 2/3 the bottom edge.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] dy_c;
    logic signed [SUM_W-1:0] dx_c;
    logic signed [SUM_W-1:0] dx_neg_c;
    logic [ADX_W-1:0]        adx_c;

    logic signed [SUM_W-1:0] s3_dy_reg;
    logic [ADX_W-1:0]        s3_adx_reg;
    logic signed [DIF_W-1:0] s3_d01x_reg;
    logic signed [DIF_W-1:0] s3_d01y_reg;
    logic signed [DIF_W-1:0] s3_d02x_reg;
    logic signed [DIF_W-1:0] s3_d02y_reg;

    always_comb
    begin
        dy_c = (SUM_W'(s2_y_reg[2]) + SUM_W'(s2_y_reg[3]))
             - (SUM_W'(s2_y_reg[0]) + SUM_W'(s2_y_reg[1]));
        dx_c = (SUM_W'(s2_x_reg[0]) + SUM_W'(s2_x_reg[1]))
             - (SUM_W'(s2_x_reg[2]) + SUM_W'(s2_x_reg[3]));
        dx_neg_c = -dx_c;
        adx_c    = dx_c[SUM_W-1] ? dx_neg_c[ADX_W-1:0] : dx_c[ADX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            s3_dy_reg   <= dy_c;
            s3_adx_reg  <= adx_c;
            s3_d01x_reg <= DIF_W'(s2_x_reg[0]) - DIF_W'(s2_x_reg[1]);
            s3_d01y_reg <= DIF_W'(s2_y_reg[0]) - DIF_W'(s2_y_reg[1]);
            s3_d02x_reg <= DIF_W'(s2_x_reg[0]) - DIF_W'(s2_x_reg[2]);
            s3_d02y_reg <= DIF_W'(s2_y_reg[0]) - DIF_W'(s2_y_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slope product and the four squared deltas
    // ------------------------------------------------------------------
    function automatic logic [SQ_W-1:0] square_of(input logic signed [DIF_W-1:0] d);
        logic signed [2*DIF_W-1:0] p;
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

    logic             s4_dy_pos_reg;
    logic [ADX_W-1:0] s4_dyv_reg;
    logic [SP_W-1:0]  s4_slope_prod_reg;
    logic [SQ_W-1:0]  s4_sq01x_reg;
    logic [SQ_W-1:0]  s4_sq01y_reg;
    logic [SQ_W-1:0]  s4_sq02x_reg;
    logic [SQ_W-1:0]  s4_sq02y_reg;

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            s4_dy_pos_reg     <= !s3_dy_reg[SUM_W-1] && (s3_dy_reg != '0);
            s4_dyv_reg        <= s3_dy_reg[ADX_W-1:0];
            s4_slope_prod_reg <= SP_W'(angle_slope_reg) * SP_W'(s3_adx_reg);
            s4_sq01x_reg      <= square_of(s3_d01x_reg);
            s4_sq01y_reg      <= square_of(s3_d01y_reg);
            s4_sq02x_reg      <= square_of(s3_d02x_reg);
            s4_sq02y_reg      <= square_of(s3_d02y_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: tilt test and squared edge lengths
    // ------------------------------------------------------------------
    logic            s5_angle_fail_reg;
    logic [D2_W-1:0] s5_w2_reg;
    logic [D2_W-1:0] s5_h2_reg;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            s5_angle_fail_reg <= !(s4_dy_pos_reg &&
                                   ((SP_W'(s4_dyv_reg) << lbqv_pkg::ANGLE_FRAC)
                                    > s4_slope_prod_reg));
            s5_w2_reg <= D2_W'(s4_sq01x_reg) + D2_W'(s4_sq01y_reg);
            s5_h2_reg <= D2_W'(s4_sq02x_reg) + D2_W'(s4_sq02y_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: ratio bound product and area partial products
    // ------------------------------------------------------------------
    logic                s6_angle_fail_reg;
    logic                s6_w_gt_h_reg;
    logic [D2_W-1:0]     s6_h2_reg;
    logic [RW_W-1:0]     s6_rw_reg;
    logic [2*LO_W-1:0]   s6_pll_reg;
    logic [LO_W+HI_W-1:0] s6_plh_reg;
    logic [LO_W+HI_W-1:0] s6_phl_reg;
    logic [2*HI_W-1:0]   s6_phh_reg;

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            s6_angle_fail_reg <= s5_angle_fail_reg;
            s6_w_gt_h_reg     <= s5_w2_reg > s5_h2_reg;
            s6_h2_reg         <= s5_h2_reg;
            s6_rw_reg         <= RW_W'(r2_reg) * RW_W'(s5_w2_reg);
            s6_pll_reg <= (2*LO_W)'(s5_w2_reg[LO_W-1:0])
                        * (2*LO_W)'(s5_h2_reg[LO_W-1:0]);
            s6_plh_reg <= (LO_W+HI_W)'(s5_w2_reg[LO_W-1:0])
                        * (LO_W+HI_W)'(s5_h2_reg[D2_W-1:LO_W]);
            s6_phl_reg <= (LO_W+HI_W)'(s5_w2_reg[D2_W-1:LO_W])
                        * (LO_W+HI_W)'(s5_h2_reg[LO_W-1:0]);
            s6_phh_reg <= (2*HI_W)'(s5_w2_reg[D2_W-1:LO_W])
                        * (2*HI_W)'(s5_h2_reg[D2_W-1:LO_W]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: ratio upper bound and the summed area product
    // ------------------------------------------------------------------
    logic            s7_angle_fail_reg;
    logic            s7_ratio_fail_reg;
    logic [AP_W-1:0] s7_area_reg;

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            s7_angle_fail_reg <= s6_angle_fail_reg;
            s7_ratio_fail_reg <= s6_w_gt_h_reg || (RW_W'(s6_h2_reg) > s6_rw_reg);
            s7_area_reg <= (AP_W'(s6_phh_reg) << (2 * LO_W))
                         + (AP_W'(s6_plh_reg) << LO_W)
                         + (AP_W'(s6_phl_reg) << LO_W)
                         + AP_W'(s6_pll_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: area test and first failing verdict
    // ------------------------------------------------------------------
    lbqv_pkg::verdict_t verdict_c;
    lbqv_pkg::verdict_t s8_verdict_reg;

    always_comb
    begin
        priority if (s7_angle_fail_reg)
            verdict_c = lbqv_pkg::VERDICT_ANGLE;
        else if (s7_ratio_fail_reg)
            verdict_c = lbqv_pkg::VERDICT_RATIO;
        else if (CMP_W'(s7_area_reg) < CMP_W'(thr_reg))
            verdict_c = lbqv_pkg::VERDICT_AREA;
        else
            verdict_c = lbqv_pkg::VERDICT_OK;
    end

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            s8_verdict_reg <= verdict_c;
        end
    end

    assign verdict = s8_verdict_reg;

endmodule

// ----- design/lbqv_checker.sv -----
`timescale 1ns / 1ps
`include "light_bar_quad_validator_unit_defines.svh"

module lbqv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input lbqv_pkg::verdict_t verdict
);

    // a stalled result beat holds
    `LBQV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(verdict), "beat lost")

    // with the output taking beats the whole pipe moves, so input is never stalled
    `LBQV_ASSERT(a_flow_free, !out_stall |-> !in_stall, "input stalled while output flows")

    // an empty output stage leaves room everywhere
    `LBQV_ASSERT(a_room_when_empty, !out_valid |-> !in_stall, "input stalled with output empty")

    // a waiting input beat means the output is full and held
    `LBQV_ASSERT(a_stall_full, in_valid && in_stall |-> out_valid && out_stall, "stall with room")

    // reset empties the pipe by the next edge
    `LBQV_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result beat after reset edge")

endmodule

bind light_bar_quad_validator_unit lbqv_checker u_lbqv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
);
